/* src/ppr_pkg.sv */
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and codes of the predecessor path recorder
// Vertex type, request and status codes, and the memory request bundle.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int VW               = 8;
  localparam int NUM_VERTICES_DEF = 64;

  typedef logic [VW-1:0] vertex_t;

  // request kinds
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_PATH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // one write port and one read port of a small memory
  typedef struct packed {
    logic    we;
    vertex_t waddr;
    vertex_t wdata;
    logic    re;
    vertex_t raddr;
  } mem_req_t;

endpackage

/* src/ppr_if.sv */
// ----------------------------------------------------------------------------
// ppr_req_if / ppr_rsp_if: request and result channels
// valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ppr_req_if import ppr_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    req_type;
  vertex_t from_vertex;
  vertex_t to_vertex;
  vertex_t source_vertex;
  vertex_t target_vertex;

  modport source (output valid, req_type, from_vertex, to_vertex, source_vertex,
                  target_vertex, input ready);
  modport sink   (input valid, req_type, from_vertex, to_vertex, source_vertex,
                  target_vertex, output ready);
endinterface

interface ppr_rsp_if import ppr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  vertex_t    path_vertex;
  logic       last;

  modport source (output valid, status, path_vertex, last, input ready);
  modport sink   (input valid, status, path_vertex, last, output ready);
endinterface

/* src/predecessor_path_recorder_top.sv */
// ----------------------------------------------------------------------------
// predecessor_path_recorder_top: predecessor table with path read-out
// Records one predecessor per vertex and walks them back to list a path.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents                                       | role
//  --------+-----+-----------------------------------------------------+------
//  req     | in  | req_type, from_vertex, to_vertex, source/target     | sink
//  rsp     | out | status, path_vertex, last                           | source
//
// An update passes through the response state, which loads its status. A path
//   walk pushes k vertices with one table read per cycle through the shared
//   compare step, then k+1 result beats follow, one per cycle unless rsp stalls.
// The request side is ready only while the sequencer is idle; the result
//   register lets the next request in while the final beat still waits.
// A stall on rsp holds the sequencer in its emit state; nothing is dropped.
// Reset clears the sequencer, the output register and the table valid bits
//   at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module predecessor_path_recorder_top import ppr_pkg::*; #(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input logic clk,
  input logic rst,
  ppr_req_if.sink   req,
  ppr_rsp_if.source rsp
);

  localparam int IW = $clog2(NUM_VERTICES);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RESP = 6'b000010,
    S_WALK = 6'b000100,
    S_SRC  = 6'b001000,
    S_POP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t  state, state_next;
  vertex_t src_q, src_next;
  vertex_t cur_q, cur_next;
  logic    from_mem, from_mem_next;
  logic [IW-1:0] depth, depth_next;
  logic [IW-1:0] depth_dec;
  status_t status_q, status_next;

  mem_req_t tbl_req, stk_req;
  vertex_t  tbl_rdata, stk_rdata;
  vertex_t  cur_sel;

  // result register
  logic    out_valid;
  status_t out_status;
  vertex_t out_vertex;
  logic    out_last;
  logic    slot_free;
  logic    load;
  status_t load_status;
  vertex_t load_vertex;
  logic    load_last;

  logic accept;

  ppr_table #(.NUM_VERTICES(NUM_VERTICES)) u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (tbl_req),
    .rdata (tbl_rdata)
  );

  ppr_stack #(.NUM_VERTICES(NUM_VERTICES)) u_stack (
    .clk   (clk),
    .req   (stk_req),
    .rdata (stk_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign depth_dec = depth - IW'(1);
  // first walk step looks at the target, later ones at the table read
  assign cur_sel   = from_mem ? tbl_rdata : cur_q;

  always_comb begin
    state_next    = state;
    src_next      = src_q;
    cur_next      = cur_q;
    from_mem_next = from_mem;
    depth_next    = depth;
    status_next   = status_q;
    tbl_req       = '0;
    stk_req       = '0;
    load          = 1'b0;
    load_status   = ST_OK;
    load_vertex   = '0;
    load_last     = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_SET) begin
            if (req.from_vertex >= vertex_t'(NUM_VERTICES) ||
                req.to_vertex >= vertex_t'(NUM_VERTICES)) begin
              status_next = ST_RANGE;
            end else begin
              status_next   = ST_OK;
              tbl_req.we    = 1'b1;
              tbl_req.waddr = req.to_vertex;
              tbl_req.wdata = req.from_vertex;
            end
            state_next = S_RESP;
          end else if (req.source_vertex >= vertex_t'(NUM_VERTICES)) begin
            status_next = ST_RANGE;
            state_next  = S_RESP;
          end else begin
            src_next      = req.source_vertex;
            cur_next      = req.target_vertex;
            from_mem_next = 1'b0;
            depth_next    = '0;
            state_next    = S_WALK;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          load        = 1'b1;
          load_status = status_q;
          state_next  = S_IDLE;
        end
      end
      S_WALK: begin
        // range check ranks above the overflow check
        priority if (cur_sel == src_q) begin
          state_next = S_SRC;
        end else if (cur_sel >= vertex_t'(NUM_VERTICES)) begin
          status_next = ST_RANGE;
          state_next  = S_RESP;
        end else if (depth == IW'(NUM_VERTICES - 1)) begin
          status_next = ST_OVERFLOW;
          state_next  = S_RESP;
        end else begin
          stk_req.we    = 1'b1;
          stk_req.waddr = vertex_t'(depth);
          stk_req.wdata = cur_sel;
          tbl_req.re    = 1'b1;
          tbl_req.raddr = cur_sel;
          depth_next    = depth + IW'(1);
          from_mem_next = 1'b1;
        end
      end
      S_SRC: begin
        if (slot_free) begin
          load        = 1'b1;
          load_vertex = src_q;
          load_last   = (depth == '0);
          if (depth == '0) begin
            state_next = S_IDLE;
          end else begin
            stk_req.re    = 1'b1;
            stk_req.raddr = vertex_t'(depth_dec);
            depth_next    = depth_dec;
            state_next    = S_POP;
          end
        end
      end
      S_POP: begin
        if (slot_free) begin
          load        = 1'b1;
          load_vertex = stk_rdata;
          load_last   = (depth == '0);
          if (depth == '0) begin
            state_next = S_DONE;
          end else begin
            stk_req.re    = 1'b1;
            stk_req.raddr = vertex_t'(depth_dec);
            depth_next    = depth_dec;
          end
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      from_mem <= 1'b0;
      depth    <= '0;
    end else begin
      state    <= state_next;
      from_mem <= from_mem_next;
      depth    <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    src_q    <= src_next;
    cur_q    <= cur_next;
    status_q <= status_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= load_status;
      out_vertex <= load_vertex;
      out_last   <= load_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.path_vertex = out_vertex;
  assign rsp.last        = out_last;

  // checks
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= IW'(NUM_VERTICES - 1))
    else $error("stack depth past vertex count");

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_last && out_vertex == '0))
    else $error("failure beat not final or carries a vertex");

  a_last_ends_req: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |=> (state == S_IDLE || state == S_DONE))
    else $error("final beat loaded but sequencer still busy");

  a_no_load_overrun: assert property (@(posedge clk) disable iff (rst)
    load |-> slot_free)
    else $error("result register overwritten while held");

endmodule

/* src/ppr_table.sv */
// ----------------------------------------------------------------------------
// ppr_table: predecessor table
// One entry per vertex with a valid bit; unwritten entries read as "none".
// ----------------------------------------------------------------------------
module ppr_table import ppr_pkg::*; #(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output vertex_t  rdata
);

  localparam int IW = $clog2(NUM_VERTICES);

  vertex_t                 mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] vld;
  vertex_t                 rd_q;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[IW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= mem[req.raddr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr[IW-1:0]] <= 1'b1;
      end
      if (req.re) begin
        rd_vld <= vld[req.raddr[IW-1:0]];
      end
    end
  end

  assign rdata = rd_vld ? rd_q : vertex_t'(NUM_VERTICES);

endmodule

/* src/ppr_stack.sv */
// ----------------------------------------------------------------------------
// ppr_stack: path stack storage
// Vertices pushed during a walk; registered read for the pops.
// ----------------------------------------------------------------------------
module ppr_stack import ppr_pkg::*; #(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output vertex_t  rdata
);

  localparam int IW = $clog2(NUM_VERTICES);

  vertex_t mem [NUM_VERTICES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[IW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[IW-1:0]];
    end
  end

endmodule

/* tb/tb_predecessor_path_recorder_top.sv */
// ----------------------------------------------------------------------------
// tb_predecessor_path_recorder_top: self-checking bench of the path recorder
// Drives update and path requests, keeps its own copy of the predecessor
// table, walks it for every accepted path request and checks every result
// beat in order against the predicted list.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_predecessor_path_recorder_top;
  import ppr_pkg::*;

  localparam int NV          = NUM_VERTICES_DEF;
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int TAIL_CYCLES = 200;      // settle time after the last result
  localparam int ITEM_TARGET = 170;
  localparam int PHASE_LEN   = 20;       // random items per idling phase

  // one request as the driver sends it, with its idling settings
  typedef struct {
    logic    req_type;
    vertex_t from_v;
    vertex_t to_v;
    vertex_t src_v;
    vertex_t tgt_v;
    int      idle_pct;       // chance that the sender idles per cycle
    int      stall_pct;      // receiver stall chance once this one is sent
    bit      wait_drain;     // hold back until every result has come
    bit      hold_rsp;       // start the long receiver hold-off
  } path_req_t;

  // one result beat
  typedef struct {
    status_t status;
    vertex_t path_vertex;
    logic    last;
  } path_beat_t;

  logic clk;
  logic rst;

  ppr_req_if req_ch ();
  ppr_rsp_if rsp_ch ();

  predecessor_path_recorder_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  path_req_t  pending_requests[$];
  path_beat_t expected_beats[$];

  // shadow of the block's predecessor table
  vertex_t link_table [NV];
  vertex_t vertex_order [NV];

  logic req_fire;          // a request beat moved at the last rising edge
  logic start_hold;
  int   hold_left;
  int   stall_pct;
  int   mismatches;

  // settings picked up by the next queued request
  int   cur_idle;
  int   cur_stall;
  bit   next_drain;
  bit   next_hold;

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void expect_beat(status_t st, vertex_t v, logic fin);
    path_beat_t b;
    b.status       = st;
    b.path_vertex  = v;
    b.last         = fin;
    expected_beats = {expected_beats, b};
  endfunction

  // Applies one accepted request to the shadow table and queues its results.
  function automatic void predict_request(logic kind, vertex_t from_v, vertex_t to_v,
                                          vertex_t src_v, vertex_t tgt_v);
    vertex_t walk [NV];
    int      depth;
    int      cur;
    if (kind == REQ_SET) begin
      if (from_v >= NV || to_v >= NV) begin
        expect_beat(ST_RANGE, '0, 1'b1);
      end else begin
        link_table[to_v] = from_v;
        expect_beat(ST_OK, '0, 1'b1);
      end
      return;
    end
    if (src_v >= NV) begin
      expect_beat(ST_RANGE, '0, 1'b1);
      return;
    end
    depth = 0;
    cur   = tgt_v;
    while (cur != src_v) begin
      // range check comes before the overflow check
      if (cur >= NV) begin
        expect_beat(ST_RANGE, '0, 1'b1);
        return;
      end
      if (depth >= NV - 1) begin
        expect_beat(ST_OVERFLOW, '0, 1'b1);
        return;
      end
      walk[depth] = vertex_t'(cur);
      depth++;
      cur = link_table[cur];
    end
    // source first, then the stack popped back toward the target
    expect_beat(ST_OK, src_v, depth == 0);
    while (depth > 0) begin
      depth--;
      expect_beat(ST_OK, walk[depth], depth == 0);
    end
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Unused fields of a request get random values so every bit toggles.
  function automatic void queue_request(logic kind, vertex_t a, vertex_t b);
    path_req_t r;
    r.req_type       = kind;
    r.from_v         = (kind == REQ_SET)  ? a : vertex_t'($urandom_range(255));
    r.to_v           = (kind == REQ_SET)  ? b : vertex_t'($urandom_range(255));
    r.src_v          = (kind == REQ_PATH) ? a : vertex_t'($urandom_range(255));
    r.tgt_v          = (kind == REQ_PATH) ? b : vertex_t'($urandom_range(255));
    r.idle_pct       = cur_idle;
    r.stall_pct      = cur_stall;
    r.wait_drain     = next_drain;
    r.hold_rsp       = next_hold;
    next_drain       = 1'b0;
    next_hold        = 1'b0;
    pending_requests = {pending_requests, r};
  endfunction

  // mostly legal vertices, one in four over the whole byte
  function automatic vertex_t pick_vertex();
    if ($urandom_range(3) == 0) return vertex_t'($urandom_range(255));
    return vertex_t'($urandom_range(NV - 1));
  endfunction

  function automatic void shuffle_vertices();
    int      j;
    vertex_t t;
    for (int i = 0; i < NV; i++) vertex_order[i] = vertex_t'(i);
    for (int i = NV - 1; i > 0; i--) begin
      j               = $urandom_range(i);
      t               = vertex_order[i];
      vertex_order[i] = vertex_order[j];
      vertex_order[j] = t;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checker and predictor: results are checked before the request of the
  // same edge is predicted; a result never comes in its request's cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_and_predict
    path_beat_t want;
    if (rst) begin
      for (int i = 0; i < NV; i++) link_table[i] = vertex_t'(NV);
      req_fire <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_beats.size() == 0) begin
          log_mismatch($sformatf("unexpected beat: status %0d vertex %0d last %0b",
                                 rsp_ch.status, rsp_ch.path_vertex, rsp_ch.last));
        end else begin
          want = expected_beats.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.path_vertex !== want.path_vertex ||
              rsp_ch.last !== want.last) begin
            log_mismatch($sformatf(
              "beat mismatch: exp status %0d vertex %0d last %0b, got %0d %0d %0b",
              want.status, want.path_vertex, want.last,
              rsp_ch.status, rsp_ch.path_vertex, rsp_ch.last));
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        predict_request(req_ch.req_type, req_ch.from_vertex, req_ch.to_vertex,
                        req_ch.source_vertex, req_ch.target_vertex);
      req_fire <= req_ch.valid && req_ch.ready;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: a new beat goes up at the falling edge once the previous
  // one moved. Each signal gets a single assignment per edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    path_req_t nxt;
    logic      go;
    logic      hold_now;
    go       = 1'b0;
    hold_now = 1'b0;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (pending_requests.size() != 0) begin
        nxt = pending_requests[0];
        go  = (!nxt.wait_drain || expected_beats.size() == 0) &&
              ($urandom_range(99) >= nxt.idle_pct);
      end
      if (go) begin
        void'(pending_requests.pop_front());
        req_ch.req_type      <= nxt.req_type;
        req_ch.from_vertex   <= nxt.from_v;
        req_ch.to_vertex     <= nxt.to_v;
        req_ch.source_vertex <= nxt.src_v;
        req_ch.target_vertex <= nxt.tgt_v;
        stall_pct            <= nxt.stall_pct;
        hold_now              = nxt.hold_rsp;
      end
      req_ch.valid <= go;
    end
    start_hold <= hold_now;
  end

  // long hold-off of the receiver, counted on its own
  always @(posedge clk) begin
    if (start_hold) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result receiver: random stalls, and no beat taken at all during the hold-off
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && hold_left == 0 && ($urandom_range(99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int      len;
    int      directed_n;
    int      long_n;
    int      phase;
    int      last_phase;
    int      pick;
    bit      long_done;
    vertex_t a;
    vertex_t b;

    clk                  = 1'b0;
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_SET;
    req_ch.from_vertex   = '0;
    req_ch.to_vertex     = '0;
    req_ch.source_vertex = '0;
    req_ch.target_vertex = '0;
    rsp_ch.ready         = 1'b0;
    req_fire             = 1'b0;
    start_hold           = 1'b0;
    hold_left            = 0;
    stall_pct            = 0;
    mismatches           = 0;
    cur_idle             = 0;
    cur_stall            = 0;
    next_drain           = 1'b0;
    next_hold            = 1'b0;
    long_done            = 1'b0;
    long_n               = 0;

    // directed part, no idling
    queue_request(REQ_PATH, 8'd0, 8'd0);       // target is source, lowest
    queue_request(REQ_PATH, 8'd63, 8'd63);     // target is source, highest
    queue_request(REQ_PATH, 8'd64, 8'd0);      // source just out of range
    queue_request(REQ_PATH, 8'd255, 8'd255);   // source far out of range
    queue_request(REQ_PATH, 8'd0, 8'd5);       // walk meets the none marker
    queue_request(REQ_PATH, 8'd0, 8'd200);     // target out of range
    queue_request(REQ_SET, 8'd255, 8'd0);      // update, from out of range
    queue_request(REQ_SET, 8'd0, 8'd64);       // update, to out of range
    queue_request(REQ_SET, 8'd170, 8'd255);    // update, both out of range
    queue_request(REQ_SET, 8'd0, 8'd63);       // legal update at the edges
    queue_request(REQ_PATH, 8'd0, 8'd63);      // two-vertex path
    queue_request(REQ_SET, 8'd0, 8'd1);        // short chain 0-1-2-3
    queue_request(REQ_SET, 8'd1, 8'd2);
    queue_request(REQ_SET, 8'd2, 8'd3);
    queue_request(REQ_PATH, 8'd0, 8'd3);
    queue_request(REQ_PATH, 8'd1, 8'd3);       // path from the middle
    queue_request(REQ_PATH, 8'd3, 8'd1);       // backwards: runs into none
    queue_request(REQ_SET, 8'd11, 8'd10);      // two-vertex loop
    queue_request(REQ_SET, 8'd10, 8'd11);
    queue_request(REQ_PATH, 8'd0, 8'd10);      // walk overflows
    queue_request(REQ_SET, 8'd20, 8'd20);      // self loop
    queue_request(REQ_PATH, 8'd0, 8'd20);      // overflows too
    queue_request(REQ_PATH, 8'd20, 8'd20);     // but ends at once here
    directed_n = pending_requests.size();

    // random part: phases of idling, mostly chains with random content;
    // the long chain does not count toward the phase length
    last_phase = -1;
    while (pending_requests.size() < ITEM_TARGET) begin
      phase = ((pending_requests.size() - directed_n - long_n) / PHASE_LEN) % 4;
      if (phase != last_phase) begin
        last_phase = phase;
        next_drain = 1'b1;
        case (phase)
          0: begin cur_idle = 0;  cur_stall = 0;  end
          1: begin cur_idle = 56; cur_stall = 0;  end
          2: begin cur_idle = 0;  cur_stall = 56; end
          default: begin cur_idle = 12; cur_stall = 12; end
        endcase
      end
      pick = $urandom_range(99);
      if (!long_done && pending_requests.size() >= 90) begin
        // full-length chain through every vertex: the longest path
        long_done = 1'b1;
        long_n    = NV + 1;
        shuffle_vertices();
        for (int i = 1; i < NV; i++)
          queue_request(REQ_SET, vertex_order[i-1], vertex_order[i]);
        next_hold = 1'b1;
        queue_request(REQ_PATH, vertex_order[0], vertex_order[NV-1]);
        queue_request(REQ_PATH, vertex_order[0], vertex_order[NV/2]);
        next_drain = 1'b1;
      end else if (pick < 50) begin
        len = $urandom_range(8, 1);
        shuffle_vertices();
        for (int i = 1; i <= len; i++)
          queue_request(REQ_SET, vertex_order[i-1], vertex_order[i]);
        if ($urandom_range(3) == 0) queue_request(REQ_SET, pick_vertex(), pick_vertex());
        queue_request(REQ_PATH, vertex_order[0], vertex_order[len]);
        if ($urandom_range(2) == 0)
          queue_request(REQ_PATH, vertex_order[$urandom_range(len)], vertex_order[len]);
      end else if (pick < 60) begin
        a = vertex_t'($urandom_range(NV - 1));
        b = vertex_t'($urandom_range(NV - 1));
        queue_request(REQ_SET, b, a);
        queue_request(REQ_SET, a, b);
        queue_request(REQ_PATH, vertex_t'($urandom_range(NV - 1)), a);
      end else if (pick < 80) begin
        queue_request(REQ_SET, pick_vertex(), pick_vertex());
      end else begin
        queue_request(REQ_PATH, pick_vertex(), pick_vertex());
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_requests.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
